### rtl/d96i_pkg.sv
// ---------------------------------------------------------------------------
// d96i_pkg
// shared types and constants of the decimal96 to int32 converter
// ---------------------------------------------------------------------------
package d96i_pkg;

  // magnitude layout
  localparam int MANT_W   = 96;
  localparam int CELL_W   = 16;
  localparam int CELLS    = MANT_W / CELL_W;
  localparam int REM_W    = 4;
  localparam int DIV_W    = CELL_W + REM_W;
  localparam int PROD_W   = 2 * DIV_W;

  // x / 10 == (x * RECIP) >> RECIP_SHIFT for every x below 2^22
  localparam logic [DIV_W-1:0] RECIP = DIV_W'(838861);
  localparam int RECIP_SHIFT = 23;

  // scale handling
  localparam int SCALE_W   = 8;
  localparam int STEP_W    = 5;
  localparam logic [SCALE_W-1:0] MAX_SCALE = SCALE_W'(28);
  // ten^29 exceeds 2^96, so more divisions leave zero
  localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(29);
  localparam int CNT_W = 6;

  localparam int INT_W = 32;
  localparam logic [INT_W-1:0] INT_MIN_BITS = {1'b1, {(INT_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic en;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

endpackage

### rtl/d96i_if.sv
// ---------------------------------------------------------------------------
// d96i_if
// valid/ready channels for decimal items and integer results
// ---------------------------------------------------------------------------
interface d96i_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] mant_low;
  logic [31:0] mant_mid;
  logic [31:0] mant_high;
  logic [7:0]  scale;
  logic        negative;

  modport source (output valid, mant_low, mant_mid, mant_high, scale, negative,
                  input ready);
  modport sink (input valid, mant_low, mant_mid, mant_high, scale, negative,
                output ready);
endinterface

interface d96i_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] int_value;
  logic               convert_error;

  modport source (output valid, int_value, convert_error, input ready);
  modport sink (input valid, int_value, convert_error, output ready);
endinterface

### rtl/d96i_cell.sv
// ---------------------------------------------------------------------------
// d96i_cell
// one 16-bit slice of the magnitude; divides by ten with carry-in remainder
// ---------------------------------------------------------------------------
module d96i_cell (
  input  logic                             clk,
  input  d96i_pkg::cell_ctrl_t             ctrl,
  input  logic [d96i_pkg::CELL_W-1:0]      load_word,
  input  logic [d96i_pkg::REM_W-1:0]       rem_in,
  output logic [d96i_pkg::CELL_W-1:0]      word,
  output logic [d96i_pkg::REM_W-1:0]       rem_out
);
  import d96i_pkg::*;

  logic [DIV_W-1:0]  dividend;
  logic [PROD_W-1:0] prod;
  logic [CELL_W-1:0] quot;
  logic [DIV_W-1:0]  quot_x10;
  logic [DIV_W-1:0]  diff;

  // remainder from the upper slice is below ten, so dividend < 10 * 2^16
  assign dividend = {rem_in, word};
  assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
  assign quot     = prod[RECIP_SHIFT +: CELL_W];
  assign quot_x10 = DIV_W'({quot, 3'b000}) + DIV_W'({quot, 1'b0});
  assign diff     = dividend - quot_x10;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= load_word;
    end else if (ctrl.en) begin
      word    <= quot;
      rem_out <= diff[REM_W-1:0];
    end
  end

endmodule

### rtl/decimal96_to_int32_top.sv
// ---------------------------------------------------------------------------
// decimal96_to_int32_top
// scaled 96-bit decimal to int32 conversion, truncating toward zero
// ---------------------------------------------------------------------------
// usage
//   req carries one decimal item: 96-bit magnitude in three words, a
//   power-of-ten scale and a sign; rsp returns int_value and convert_error
//   an item is taken when valid and ready are both high on a rising edge
// operation
//   the magnitude sits in a row of six 16-bit cells; every enabled cell
//   divides its slice by ten using the remainder its upper neighbor left
//   in the cycle before, so successive divisions run as a skewed wavefront
//   n = min(scale, 29) divisions are done, since more always give zero
// flow
//   an item passes through n division steps, the skew across the row and
//   the output register before its result is valid on rsp
//   one item at a time: req.ready is high only while no item is at work,
//   so the next item is taken once the last has moved into the output
//   register at the soonest, even while that result still waits on rsp
// reset and stall
//   rst (synchronous, active high) empties the row and drops rsp.valid
//   when rsp stalls, the result stays in the output register; a finished
//   item waits in the row until that register frees, holding off req
// ---------------------------------------------------------------------------
module decimal96_to_int32_top (
  input logic       clk,
  input logic       rst,
  d96i_in_if.sink   req,
  d96i_out_if.source rsp
);
  import d96i_pkg::*;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]  cnt;
  logic [STEP_W-1:0] step_count;
  logic              neg_flag;
  logic              scale_err;

  logic              req_fire;
  logic              done;
  logic              load_out;
  logic [CNT_W-1:0]  last_cnt;
  logic [STEP_W-1:0] steps_in;

  logic [MANT_W-1:0] mant_in;
  logic [MANT_W-1:0] quot_all;
  logic [CELL_W-1:0] words [CELLS];
  logic [REM_W-1:0]  rems [CELLS+1];

  logic              en_head;
  logic [CELLS-1:1]  en_tail;
  logic [CELLS-1:0]  en;

  logic              hi_nonzero;
  logic              min_case;
  logic              overflow;
  logic [INT_W-1:0]  mag32;
  logic [INT_W-1:0]  value_bits;
  logic              err_bit;

  logic               out_valid;
  logic signed [INT_W-1:0] out_value;
  logic               out_err;

  // handshake
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  assign steps_in = (req.scale > SCALE_W'(STEP_CAP)) ? STEP_CAP : req.scale[STEP_W-1:0];
  assign mant_in  = {req.mant_high, req.mant_mid, req.mant_low};

  // done marks the end of the run, once the last cell has made its final division
  assign last_cnt = CNT_W'(step_count) + CNT_W'(CELLS - 1);
  assign done     = (state == S_RUN) && (cnt == last_cnt);
  assign load_out = (done || (state == S_HOLD)) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_fire) state_next = S_RUN;
      S_RUN: begin
        if (done) state_next = load_out ? S_IDLE : S_HOLD;
      end
      S_HOLD: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (req_fire) begin
        cnt <= '0;
      end else if (state == S_RUN) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // item attributes kept for the run
  always_ff @(posedge clk) begin
    if (req_fire) begin
      step_count <= steps_in;
      neg_flag   <= req.negative;
      scale_err  <= (req.scale > MAX_SCALE);
    end
  end

  // division tokens enter the top cell and move down one cell a cycle
  assign en_head = (state == S_RUN) && (cnt < CNT_W'(step_count));
  assign en      = {en_tail, en_head};

  always_ff @(posedge clk) begin
    if (rst) begin
      en_tail <= '0;
    end else begin
      for (int j = 1; j < CELLS; j++) begin
        en_tail[j] <= en[j-1];
      end
    end
  end

  // row of cells, cell 0 holds the most significant slice
  assign rems[0] = '0;

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    cell_ctrl_t ctrl;

    assign ctrl.load = req_fire;
    assign ctrl.en   = en[j];

    d96i_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_word (mant_in[MANT_W-1-j*CELL_W -: CELL_W]),
      .rem_in    (rems[j]),
      .word      (words[j]),
      .rem_out   (rems[j+1])
    );

    assign quot_all[MANT_W-1-j*CELL_W -: CELL_W] = words[j];
  end

  // range check and sign
  assign hi_nonzero = |quot_all[MANT_W-1:INT_W];
  assign min_case   = neg_flag && !hi_nonzero && (quot_all[INT_W-1:0] == INT_MIN_BITS);
  assign overflow   = hi_nonzero || quot_all[INT_W-1];
  assign mag32      = {1'b0, quot_all[INT_W-2:0]};

  always_comb begin
    priority if (min_case) begin
      value_bits = INT_MIN_BITS;
    end else if (neg_flag) begin
      value_bits = -mag32;
    end else begin
      value_bits = mag32;
    end
  end

  assign err_bit = scale_err || (overflow && !min_case);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= $signed(value_bits);
      out_err   <= err_bit;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.int_value     = out_value;
  assign rsp.convert_error = out_err;

endmodule

### rtl/d96i_checker.sv
// ---------------------------------------------------------------------------
// d96i_checker
// port-level checks of the converter, attached to the top level by bind
// ---------------------------------------------------------------------------
module d96i_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] int_value,
  input logic        convert_error
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a taken item occupies the row, so no second item is taken right after
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item taken while another is at work");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(int_value) && $stable(convert_error)))
    else $error("stalled result changed");

endmodule

bind decimal96_to_int32_top d96i_checker u_d96i_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .int_value     (rsp.int_value),
  .convert_error (rsp.convert_error)
);

### verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// checks decimal96_to_int32_top: each decimal item that req takes is run
// through a local truncating conversion, and every result on rsp is compared
// with the oldest prediction still owed; both channels idle and stall at random
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import d96i_pkg::*;

  // one decimal item as it travels on req
  typedef struct packed {
    logic [31:0] mant_low;
    logic [31:0] mant_mid;
    logic [31:0] mant_high;
    logic [7:0]  scale;
    logic        negative;
  } decimal_t;

  // one integer result as it travels on rsp
  typedef struct packed {
    logic [INT_W-1:0] int_value;
    logic             convert_error;
  } int32_res_t;

  localparam int RANDOM_ITEMS = 1050;
  // room for every item at its worst: longest gap, run at work and stall, several times over
  localparam int CYCLE_LIMIT = 1_000_000;
  // covers the longest conversion of the top level, with margin
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  d96i_in_if  req_if ();
  d96i_out_if rsp_if ();

  decimal96_to_int32_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  decimal_t   decimal_q[$];    // items still to be sent
  int32_res_t int32_due_q[$];  // predicted results not yet seen on rsp
  int         fails  = 0;
  int         cycles = 0;

  // --- prediction -----------------------------------------------------------

  // truncate toward zero: divide by ten once per scale step, stop at zero
  function automatic int32_res_t truncate_to_int32(decimal_t d);
    logic [95:0] q;
    logic [30:0] low31;
    int          i;
    int32_res_t  r;
    q = {d.mant_high, d.mant_mid, d.mant_low};
    for (i = 0; i < int'(d.scale) && q != '0; i++) q = q / 96'd10;
    low31 = q[30:0];
    if (d.negative && q == 96'h8000_0000) begin
      // exactly -2^31 is representable
      r.int_value     = INT_MIN_BITS;
      r.convert_error = (d.scale > MAX_SCALE);
    end else begin
      r.int_value     = d.negative ? -{1'b0, low31} : {1'b0, low31};
      r.convert_error = (q[95:31] != '0) || (d.scale > MAX_SCALE);
    end
    return r;
  endfunction

  // --- stimulus helpers -----------------------------------------------------

  function automatic decimal_t make_decimal(logic [95:0] m, logic [7:0] sc, logic neg);
    decimal_t d;
    {d.mant_high, d.mant_mid, d.mant_low} = m;
    d.scale    = sc;
    d.negative = neg;
    return d;
  endfunction

  function automatic logic [191:0] pow10(int n);
    logic [191:0] p;
    p = 192'd1;
    repeat (n) p = p * 192'd10;
    return p;
  endfunction

  // most items aim the truncated value at a chosen region, then pad the
  // magnitude with a random remainder below ten^scale
  function automatic decimal_t random_decimal();
    logic [191:0] q;
    logic [191:0] p;
    logic [191:0] m;
    int unsigned  sc;
    int unsigned  kind;
    sc   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 29);
    kind = $urandom_range(0, 5);
    case (kind)
      0: q = 192'($urandom_range(0, 1000));
      1: q = 192'h8000_0000 - 192'd4 + 192'($urandom_range(0, 8));
      2: q = 192'($urandom);
      3: q = 192'({$urandom, $urandom} >> $urandom_range(0, 63));
      default: q = '0;
    endcase
    if (kind <= 3 && sc <= 28) begin
      p = pow10(sc);
      m = q * p + ({$urandom, $urandom, $urandom, $urandom} % p);
    end else begin
      m = '1;
    end
    // out of 96 bits or no target: any magnitude of random width
    if (m[191:96] != '0)
      m = 192'({$urandom, $urandom, $urandom} >> $urandom_range(0, 95));
    return make_decimal(m[95:0], 8'(sc), 1'($urandom_range(0, 1)));
  endfunction

  // mostly short gaps, a few long ones, none at all in a calm stretch
  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 45);
  endfunction

  // --- driver: feeds req from decimal_q -------------------------------------

  decimal_t    sent;
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      // item taken at this edge: its result is now owed
      if (req_if.valid && req_if.ready)
        int32_due_q.push_back(truncate_to_int32(sent));
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (decimal_q.size() > 0) begin
          sent = decimal_q.pop_front();
          req_if.mant_low  <= sent.mant_low;
          req_if.mant_mid  <= sent.mant_mid;
          req_if.mant_high <= sent.mant_high;
          req_if.scale     <= sent.scale;
          req_if.negative  <= sent.negative;
          req_if.valid     <= 1'b1;
          if ($urandom_range(0, 49) == 0) send_calm = ~send_calm;
          send_gap = idle_len(send_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --- monitor: checks rsp against int32_due_q ------------------------------

  int32_res_t  want;
  int unsigned recv_stall = 0;
  bit          recv_calm  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (int32_due_q.size() == 0) begin
          $error("result with no item outstanding: int_value=%0d convert_error=%0b",
                 $signed(rsp_if.int_value), rsp_if.convert_error);
          fails++;
        end else begin
          want = int32_due_q.pop_front();
          if (rsp_if.int_value !== want.int_value) begin
            $error("int_value: expected %0d, got %0d",
                   $signed(want.int_value), $signed(rsp_if.int_value));
            fails++;
          end
          if (rsp_if.convert_error !== want.convert_error) begin
            $error("convert_error: expected %0b, got %0b",
                   want.convert_error, rsp_if.convert_error);
            fails++;
          end
        end
      end
      // random back-pressure on rsp
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 63) == 0) recv_calm = ~recv_calm;
        recv_stall = idle_len(recv_calm);
      end
    end
  end

  // --- watchdog -------------------------------------------------------------

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --- sequence -------------------------------------------------------------

  initial begin
    logic [95:0] two31_e18;
    // known levels on every input before the first edge
    req_if.valid     = 1'b0;
    req_if.mant_low  = '0;
    req_if.mant_mid  = '0;
    req_if.mant_high = '0;
    req_if.scale     = '0;
    req_if.negative  = 1'b0;
    rsp_if.ready     = 1'b0;

    two31_e18 = 96'(192'h8000_0000 * pow10(18));

    // zero and negative zero
    decimal_q.push_back(make_decimal(96'd0, 8'd0, 1'b0));
    decimal_q.push_back(make_decimal(96'd0, 8'd0, 1'b1));
    decimal_q.push_back(make_decimal(96'd0, 8'd255, 1'b1));
    // edges of the int32 range, unscaled
    decimal_q.push_back(make_decimal(96'h7FFF_FFFF, 8'd0, 1'b0));
    decimal_q.push_back(make_decimal(96'h7FFF_FFFF, 8'd0, 1'b1));
    decimal_q.push_back(make_decimal(96'h8000_0000, 8'd0, 1'b1));
    decimal_q.push_back(make_decimal(96'h8000_0000, 8'd0, 1'b0));
    decimal_q.push_back(make_decimal(96'h8000_0001, 8'd0, 1'b1));
    decimal_q.push_back(make_decimal(96'hFFFF_FFFF, 8'd0, 1'b0));
    // full magnitude at the scale limits
    decimal_q.push_back(make_decimal('1, 8'd0, 1'b0));
    decimal_q.push_back(make_decimal('1, 8'd0, 1'b1));
    decimal_q.push_back(make_decimal('1, 8'd28, 1'b0));
    decimal_q.push_back(make_decimal('1, 8'd28, 1'b1));
    decimal_q.push_back(make_decimal('1, 8'd29, 1'b0));
    decimal_q.push_back(make_decimal('1, 8'd255, 1'b1));
    // truncation landing on the range edges
    decimal_q.push_back(make_decimal(96'd21474836489, 8'd1, 1'b1));
    decimal_q.push_back(make_decimal(96'd21474836479, 8'd1, 1'b0));
    decimal_q.push_back(make_decimal(96'd21474836480, 8'd1, 1'b0));
    decimal_q.push_back(make_decimal(two31_e18 + 96'(pow10(18)) - 96'd1, 8'd18, 1'b1));
    decimal_q.push_back(make_decimal(two31_e18 - 96'd1, 8'd18, 1'b0));
    // a full high word alone, alternating bit patterns, small scaled values
    decimal_q.push_back(make_decimal({32'hFFFF_FFFF, 64'd0}, 8'd10, 1'b0));
    decimal_q.push_back(make_decimal({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
                                     8'd20, 1'b1));
    decimal_q.push_back(make_decimal({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
                                     8'd21, 1'b0));
    decimal_q.push_back(make_decimal(96'd123456789, 8'd5, 1'b1));
    decimal_q.push_back(make_decimal(96'd9, 8'd28, 1'b0));

    repeat (RANDOM_ITEMS) decimal_q.push_back(random_decimal());

    // hold reset, then release it once
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // everything sent and taken, then every result seen
    while (decimal_q.size() != 0 || req_if.valid) @(posedge clk);
    while (int32_due_q.size() != 0) @(posedge clk);
    // catch any stray result after the last one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
